[sv/cwb_pkg.sv]
// shared types, constants and table builder for the cylindrical warp block
package cwb_pkg;

  localparam int unsigned CHAN_W       = 16;
  localparam int unsigned OUT_CHANNELS = 3;
  localparam int unsigned COORD_W      = 8;
  localparam int unsigned DIM_W        = 9;
  localparam int unsigned FOCAL_W      = 24;
  localparam int unsigned CFG_ADDR_W   = 4;
  localparam int unsigned CFG_DATA_W   = 32;

  localparam logic [DIM_W-1:0]   WIDTH_RST     = 9'd256;
  localparam logic [DIM_W-1:0]   HEIGHT_RST    = 9'd256;
  localparam logic [FOCAL_W-1:0] FOCAL_RST     = 24'd65536;
  localparam logic [FOCAL_W-1:0] INV_FOCAL_RST = 24'd65536;

  localparam logic [24:0] HALF_PI_Q16 = 25'd102944;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] SAT24       = 64'hFF_FFFF;

  typedef enum logic [1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_FOCAL_IN  = 2'd2,
    REG_INV_FOCAL = 2'd3
  } cwb_reg_e;

  typedef struct packed {
    logic                                  query;
    logic [COORD_W-1:0]                    row;
    logic [COORD_W-1:0]                    col;
    logic [OUT_CHANNELS-1:0][CHAN_W-1:0]   pix;
  } cwb_meta_t;

  typedef struct packed {
    logic             ok;
    logic [DIM_W-1:0] r0;
    logic [7:0]       dr;
    logic [DIM_W-1:0] c0;
    logic [7:0]       dc;
  } cwb_geom_t;

  typedef struct packed {
    logic [OUT_CHANNELS-1:0][CHAN_W-1:0] chan;
    logic                                in_range;
  } cwb_beat_t;

  // restoring long division, elaboration use only
  function automatic logic [63:0] cwb_udiv(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // one angle entry, {sec, tan} in Q8.16, saturated from a quarter turn on
  function automatic logic [47:0] cwb_angle_entry(input int unsigned k,
                                                  input int unsigned entries);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        ts;
    logic [63:0]        tc;
    logic [63:0]        cu;
    logic [63:0]        t;
    logic [63:0]        q;
    logic signed [63:0] s;
    logic signed [63:0] c;
    x = cwb_udiv(64'(k) << 31, 64'(entries));
    if (x >= HALF_PI_Q30) begin
      return {SAT24[23:0], SAT24[23:0]};
    end
    x2 = (x * x) >> 30;
    s  = signed'(x);
    c  = 64'sd1 <<< 30;
    ts = x;
    tc = 64'd1 << 30;
    for (int n = 1; n <= 12; n++) begin
      ts = cwb_udiv((ts * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
      tc = cwb_udiv((tc * x2) >> 30, 64'((2 * n - 1) * (2 * n)));
      if (n[0]) begin
        s = s - signed'(ts);
        c = c - signed'(tc);
      end else begin
        s = s + signed'(ts);
        c = c + signed'(tc);
      end
    end
    if (c <= 0) begin
      return {SAT24[23:0], SAT24[23:0]};
    end
    if (s < 0) begin
      s = '0;
    end
    cu = unsigned'(c);
    t  = cwb_udiv((unsigned'(s) << 16) + (cu >> 1), cu);
    q  = cwb_udiv((64'd1 << 46) + (cu >> 1), cu);
    if (t > SAT24) t = SAT24;
    if (q > SAT24) q = SAT24;
    return {q[23:0], t[23:0]};
  endfunction

endpackage

[sv/cwb_ram.sv]
// generic simple dual port ram with registered read
module cwb_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/cwb_geom.sv]
// coordinate pipeline: column angle, tan/sec lookup and source position
module cwb_geom #(
  parameter int unsigned ANGLE_TABLE_ENTRIES = 1024
) (
  input  logic                   clk_i,
  input  logic                   adv_i,
  input  logic [7:0]             row_i,
  input  logic [7:0]             col_i,
  input  logic [8:0]             width_i,
  input  logic [8:0]             height_i,
  input  logic [23:0]            focal_i,
  input  logic [23:0]            inv_focal_i,
  output cwb_pkg::cwb_geom_t     geom_o
);
  import cwb_pkg::*;

  localparam int unsigned IDX_W = $clog2(ANGLE_TABLE_ENTRIES);
  localparam int unsigned PW    = 18 + IDX_W;
  localparam logic [IDX_W:0]   ENT_V  = (IDX_W + 1)'(ANGLE_TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_I = IDX_W'(ANGLE_TABLE_ENTRIES - 1);

  // angle rom, each word holds entry k and its upper neighbour
  logic [47:0] ent  [ANGLE_TABLE_ENTRIES];
  logic [95:0] word [ANGLE_TABLE_ENTRIES];

  for (genvar k = 0; k < ANGLE_TABLE_ENTRIES; k++) begin : g_ent
    localparam logic [47:0] ENT_K = cwb_angle_entry(k, ANGLE_TABLE_ENTRIES);
    assign ent[k] = ENT_K;
    if (k + 1 < ANGLE_TABLE_ENTRIES) begin : g_mid
      assign word[k] = {ent[k + 1], ent[k]};
    end else begin : g_top
      assign word[k] = {ent[k], ent[k]};
    end
  end

  // stage 0 distances from the centre
  logic       negx, negy;
  logic [8:0] dxm, dym;
  always_comb begin
    negx = ({col_i, 1'b0} < width_i);
    negy = ({row_i, 1'b0} < height_i);
    dxm  = negx ? width_i - {col_i, 1'b0} : {col_i, 1'b0} - width_i;
    dym  = negy ? height_i - {row_i, 1'b0} : {row_i, 1'b0} - height_i;
  end

  // stage 1
  logic [32:0] ax_q, ay1_q;
  logic        negx1_q, negy1_q;
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ax_q    <= 33'(dxm) * 33'(inv_focal_i);
      ay1_q   <= 33'(dym) * 33'(inv_focal_i);
      negx1_q <= negx;
      negy1_q <= negy;
    end
  end

  // stage 2: theta, rom index and rom read
  logic [33:0]      a_sum;
  logic [24:0]      ang;
  logic [PW-1:0]    pos;
  logic [IDX_W:0]   idx_full;
  logic [IDX_W-1:0] idx;
  always_comb begin
    a_sum    = 34'(ax_q) + 34'd256;
    ang      = a_sum[33:9];
    pos      = PW'(ang[16:0]) * PW'(ANGLE_TABLE_ENTRIES);
    idx_full = pos[PW-1:17];
    idx      = (idx_full >= ENT_V) ? LAST_I : idx_full[IDX_W-1:0];
  end

  logic [95:0] rom_q;
  logic [16:0] f_q;
  logic        wide2_q, negx2_q, negy2_q;
  logic [32:0] ay2_q;
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rom_q   <= word[idx];
      f_q     <= pos[16:0];
      wide2_q <= (ang >= HALF_PI_Q16);
      ay2_q   <= ay1_q;
      negx2_q <= negx1_q;
      negy2_q <= negy1_q;
    end
  end

  // stage 3: interpolation products
  logic [17:0] fc;
  assign fc = 18'd131072 - {1'b0, f_q};

  logic [41:0] mt0_q, mt1_q, ms0_q, ms1_q;
  logic        wide3_q, negx3_q, negy3_q;
  logic [32:0] ay3_q;
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mt0_q   <= 42'(rom_q[23:0])  * 42'(fc);
      ms0_q   <= 42'(rom_q[47:24]) * 42'(fc);
      mt1_q   <= 42'(rom_q[71:48]) * 42'(f_q);
      ms1_q   <= 42'(rom_q[95:72]) * 42'(f_q);
      wide3_q <= wide2_q;
      ay3_q   <= ay2_q;
      negx3_q <= negx2_q;
      negy3_q <= negy2_q;
    end
  end

  // stage 4: tan and sec
  logic [42:0] tsum, ssum;
  assign tsum = 43'(mt0_q) + 43'(mt1_q) + 43'd65536;
  assign ssum = 43'(ms0_q) + 43'(ms1_q) + 43'd65536;

  logic [23:0] tanm_q, secv_q;
  logic        wide4_q, negx4_q, negy4_q;
  logic [32:0] ay4_q;
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tanm_q  <= tsum[40:17];
      secv_q  <= ssum[40:17];
      wide4_q <= wide3_q;
      ay4_q   <= ay3_q;
      negx4_q <= negx3_q;
      negy4_q <= negy3_q;
    end
  end

  // stage 5: scale by focal length and secant
  logic [47:0] cmp_q;
  logic [56:0] ysp_q;
  logic        wide5_q, negx5_q, negy5_q;
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cmp_q   <= 48'(focal_i) * 48'(tanm_q);
      ysp_q   <= 57'(ay4_q) * 57'(secv_q);
      wide5_q <= wide4_q;
      negx5_q <= negx4_q;
      negy5_q <= negy4_q;
    end
  end

  // stage 6: source column and bounds
  logic [48:0]        cm_sum;
  logic [32:0]        cm;
  logic signed [34:0] cpos;
  logic               col_ok;
  logic [57:0]        ys_sum;
  logic [40:0]        ys;
  always_comb begin
    cm_sum = 49'(cmp_q) + 49'd32768;
    cm     = cm_sum[48:16];
    cpos   = negx5_q ? signed'(35'({width_i, 7'b0})) - signed'(35'(cm))
                     : signed'(35'({width_i, 7'b0})) + signed'(35'(cm));
    col_ok = !cpos[34] && (unsigned'(cpos) < 35'({width_i - 9'd1, 8'b0}));
    ys_sum = 58'(ysp_q) + 58'd65536;
    ys     = ys_sum[57:17];
  end

  logic [19:0] yl_q;
  logic [20:0] yh_q;
  logic        ok6_q, negy6_q;
  logic [8:0]  c06_q;
  logic [7:0]  dc6_q;
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      yl_q    <= ys[19:0];
      yh_q    <= ys[40:20];
      ok6_q   <= !wide5_q && col_ok;
      c06_q   <= cpos[16:8];
      dc6_q   <= cpos[7:0];
      negy6_q <= negy5_q;
    end
  end

  // stage 7: row offset split in two partial products
  logic [43:0] pl_q;
  logic [44:0] ph_q;
  logic        ok7_q, negy7_q;
  logic [8:0]  c07_q;
  logic [7:0]  dc7_q;
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pl_q    <= 44'(yl_q) * 44'(focal_i);
      ph_q    <= 45'(yh_q) * 45'(focal_i);
      ok7_q   <= ok6_q;
      c07_q   <= c06_q;
      dc7_q   <= dc6_q;
      negy7_q <= negy6_q;
    end
  end

  // stage 8: source row and bounds
  logic [65:0]        rsum;
  logic [41:0]        rm;
  logic signed [43:0] rpos;
  logic               row_ok;
  always_comb begin
    rsum   = (66'(ph_q) << 20) + 66'(pl_q) + 66'd8388608;
    rm     = rsum[65:24];
    rpos   = negy7_q ? signed'(44'({height_i, 7'b0})) - signed'(44'(rm))
                     : signed'(44'({height_i, 7'b0})) + signed'(44'(rm));
    row_ok = !rpos[43] && (unsigned'(rpos) < 44'({height_i - 9'd1, 8'b0}));
  end

  cwb_geom_t geom_q;
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      geom_q.ok <= ok7_q && row_ok;
      geom_q.r0 <= rpos[16:8];
      geom_q.dr <= rpos[7:0];
      geom_q.c0 <= c07_q;
      geom_q.dc <= dc7_q;
    end
  end

  assign geom_o = geom_q;

endmodule

[sv/cwb_lane.sv]
// one channel lane: two-step bilinear blend of the four neighbours
module cwb_lane #(
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  adv_i,
  input  logic [PIXEL_BITS-1:0] p00_i,
  input  logic [PIXEL_BITS-1:0] p01_i,
  input  logic [PIXEL_BITS-1:0] p10_i,
  input  logic [PIXEL_BITS-1:0] p11_i,
  input  logic [7:0]            dc_i,
  input  logic [7:0]            dr_i,
  output logic [15:0]           val_o
);

  localparam int unsigned TW = PIXEL_BITS + 9;
  localparam int unsigned VW = PIXEL_BITS + 18;

  logic [8:0] wc0;
  assign wc0 = 9'd256 - {1'b0, dc_i};

  logic [TW-1:0] top_q, bot_q;
  logic [7:0]    dr_q;
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      top_q <= TW'(wc0) * TW'(p00_i) + TW'(dc_i) * TW'(p01_i);
      bot_q <= TW'(wc0) * TW'(p10_i) + TW'(dc_i) * TW'(p11_i);
      dr_q  <= dr_i;
    end
  end

  logic [8:0]    wr0;
  logic [VW-1:0] vsum;
  logic [VW-1:0] vsh;
  always_comb begin
    wr0  = 9'd256 - {1'b0, dr_q};
    vsum = VW'(wr0) * VW'(top_q) + VW'(dr_q) * VW'(bot_q) + VW'(32768);
    vsh  = vsum >> 16;
  end

  logic [15:0] val_q;
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      val_q <= 16'(vsh);
    end
  end

  assign val_o = val_q;

endmodule

[sv/cwb_merge.sv]
// merges lane results into the output beat, output register plus skid
module cwb_merge #(
  parameter int unsigned CHANNEL_COUNT = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic                          ok_i,
  input  logic [CHANNEL_COUNT-1:0][15:0] lane_i,
  input  logic                          m_axis_tready,
  output logic                          m_axis_tvalid,
  output logic [47:0]                   m_axis_tdata,
  output logic [0:0]                    m_axis_tuser,
  output logic                          adv_o
);
  import cwb_pkg::*;

  cwb_beat_t beat;
  always_comb begin
    beat          = '0;
    beat.in_range = ok_i;
    for (int ch = 0; ch < OUT_CHANNELS; ch++) begin
      if (ch < CHANNEL_COUNT && ok_i) begin
        beat.chan[ch] = lane_i[ch];
      end
    end
  end

  logic      out_valid_q, skid_valid_q;
  cwb_beat_t out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && !m_axis_tready) begin
      if (push_i) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && !m_axis_tready) begin
      if (push_i) begin
        skid_q <= beat;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else if (push_i) begin
      out_q <= beat;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.chan;
  assign m_axis_tuser  = out_q.in_range;
  // pipeline moves only while the skid slot is free
  assign adv_o         = !skid_valid_q;

endmodule

[sv/cylindrical_warp_bilinear.sv]
// Cylindrical projection remap with bilinear sampling. Load beats (tuser 0)
// write one pixel into a 2x2-banked image store; query beats (tuser 1) name
// an output pixel and return the blend of its four source neighbours, or
// zeros with in_range low when the angle reaches a quarter turn or a
// neighbour falls outside the image. One beat is accepted every clock while
// the skid slot is free; the four single-port-read memory banks (one per
// row/column parity) hand over all four neighbours in the same cycle.
// Loads write at the same pipeline depth at which queries read, so beats
// see the store exactly in arrival order. A stall on the output holds the
// whole pipeline as soon as the skid slot fills.
module cylindrical_warp_bilinear #(
  parameter int unsigned MAX_WIDTH           = 256,
  parameter int unsigned MAX_HEIGHT          = 256,
  parameter int unsigned PIXEL_BITS          = 16,
  parameter int unsigned CHANNEL_COUNT       = 3,
  parameter int unsigned ANGLE_TABLE_ENTRIES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // row, col, chan0_in, chan1_in, chan2_in
  input  logic [0:0]  s_axis_tuser,  // mode
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // chan0_out, chan1_out, chan2_out
  output logic [0:0]  m_axis_tuser   // in_range
);
  import cwb_pkg::*;

  localparam int unsigned HALF_W     = (MAX_WIDTH + 1) / 2;
  localparam int unsigned HALF_H     = (MAX_HEIGHT + 1) / 2;
  localparam int unsigned BANK_DEPTH = HALF_W * HALF_H;
  localparam int unsigned AW         = $clog2(BANK_DEPTH);
  localparam int unsigned WORD_W     = CHANNEL_COUNT * PIXEL_BITS;
  localparam int unsigned GEOM_LAT   = 8;

  // configuration registers
  logic [8:0]  width_q, height_q;
  logic [23:0] focal_q, inv_focal_q;
  cwb_reg_e    reg_idx;

  assign reg_idx = cwb_reg_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= WIDTH_RST;
      height_q    <= HEIGHT_RST;
      focal_q     <= FOCAL_RST;
      inv_focal_q <= INV_FOCAL_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_WIDTH:     width_q     <= pwdata[8:0];
        REG_HEIGHT:    height_q    <= pwdata[8:0];
        REG_FOCAL_IN:  focal_q     <= pwdata[23:0];
        REG_INV_FOCAL: inv_focal_q <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH:     prdata = 32'(width_q);
      REG_HEIGHT:    prdata = 32'(height_q);
      REG_FOCAL_IN:  prdata = 32'(focal_q);
      REG_INV_FOCAL: prdata = 32'(inv_focal_q);
      default:       prdata = '0;
    endcase
  end

  // dimensions in use, clamped to the store
  logic [8:0] w_use, h_use;
  always_comb begin
    if (width_q < 9'd2) w_use = 9'd2;
    else if (32'(width_q) > 32'(MAX_WIDTH)) w_use = 9'(MAX_WIDTH);
    else w_use = width_q;
    if (height_q < 9'd2) h_use = 9'd2;
    else if (32'(height_q) > 32'(MAX_HEIGHT)) h_use = 9'(MAX_HEIGHT);
    else h_use = height_q;
  end

  // input register and side pipeline that walks beside the geometry unit
  logic adv;
  assign s_axis_tready = adv;

  logic      [GEOM_LAT:0] valid_q;
  cwb_meta_t              meta_q [GEOM_LAT+1];
  cwb_meta_t              meta_in;

  always_comb begin
    meta_in.query  = s_axis_tuser[0];
    meta_in.row    = s_axis_tdata[7:0];
    meta_in.col    = s_axis_tdata[15:8];
    meta_in.pix[0] = s_axis_tdata[31:16];
    meta_in.pix[1] = s_axis_tdata[47:32];
    meta_in.pix[2] = s_axis_tdata[63:48];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[GEOM_LAT-1:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      meta_q[0] <= meta_in;
      for (int s = 1; s <= GEOM_LAT; s++) begin
        meta_q[s] <= meta_q[s-1];
      end
    end
  end

  cwb_geom_t geom;

  cwb_geom #(
    .ANGLE_TABLE_ENTRIES(ANGLE_TABLE_ENTRIES)
  ) u_geom (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .row_i      (meta_q[0].row),
    .col_i      (meta_q[0].col),
    .width_i    (w_use),
    .height_i   (h_use),
    .focal_i    (focal_q),
    .inv_focal_i(inv_focal_q),
    .geom_o     (geom)
  );

  // store access: one bank per row and column parity
  cwb_meta_t m8;
  logic      load_ok;
  logic [AW-1:0] waddr;
  logic [WORD_W-1:0] wdata;
  assign m8 = meta_q[GEOM_LAT];

  always_comb begin
    load_ok = (32'(m8.row) < 32'(MAX_HEIGHT)) && (32'(m8.col) < 32'(MAX_WIDTH));
    waddr   = AW'(32'(m8.row[7:1]) * 32'(HALF_W) + 32'(m8.col[7:1]));
    for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
      wdata[ch*PIXEL_BITS +: PIXEL_BITS] = PIXEL_BITS'(m8.pix[ch]);
    end
  end

  logic [WORD_W-1:0] rd [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic PR = 1'(b >> 1);
    localparam logic PC = 1'(b & 1);
    logic [9:0]    rr, cc;
    logic [AW-1:0] raddr;
    logic          we;
    always_comb begin
      rr    = 10'(geom.r0) + 10'(geom.r0[0] ^ PR);
      cc    = 10'(geom.c0) + 10'(geom.c0[0] ^ PC);
      raddr = AW'(32'(rr[9:1]) * 32'(HALF_W) + 32'(cc[9:1]));
      we    = adv && valid_q[GEOM_LAT] && !m8.query && load_ok &&
              (m8.row[0] == PR) && (m8.col[0] == PC);
    end

    cwb_ram #(
      .WIDTH(WORD_W),
      .DEPTH(BANK_DEPTH)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (we),
      .waddr_i(waddr),
      .wdata_i(wdata),
      .re_i   (adv),
      .raddr_i(raddr),
      .rdata_o(rd[b])
    );
  end

  // stage 9 alongside the read data
  logic [2:0] v_q;     // valid queries at stages 9, 10, 11
  logic [2:0] ok_q;
  logic       pr9_q, pc9_q;
  logic [7:0] dc9_q, dr9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[1:0], valid_q[GEOM_LAT] && m8.query};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok_q  <= {ok_q[1:0], geom.ok};
      pr9_q <= geom.r0[0];
      pc9_q <= geom.c0[0];
      dc9_q <= geom.dc;
      dr9_q <= geom.dr;
    end
  end

  logic [WORD_W-1:0] w00, w01, w10, w11;
  always_comb begin
    w00 = rd[{pr9_q, pc9_q}];
    w01 = rd[{pr9_q, !pc9_q}];
    w10 = rd[{!pr9_q, pc9_q}];
    w11 = rd[{!pr9_q, !pc9_q}];
  end

  logic [CHANNEL_COUNT-1:0][15:0] lane_val;

  for (genvar ch = 0; ch < CHANNEL_COUNT; ch++) begin : g_lane
    cwb_lane #(
      .PIXEL_BITS(PIXEL_BITS)
    ) u_lane (
      .clk_i(clk_i),
      .adv_i(adv),
      .p00_i(w00[ch*PIXEL_BITS +: PIXEL_BITS]),
      .p01_i(w01[ch*PIXEL_BITS +: PIXEL_BITS]),
      .p10_i(w10[ch*PIXEL_BITS +: PIXEL_BITS]),
      .p11_i(w11[ch*PIXEL_BITS +: PIXEL_BITS]),
      .dc_i (dc9_q),
      .dr_i (dr9_q),
      .val_o(lane_val[ch])
    );
  end

  cwb_merge #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (adv && v_q[2]),
    .ok_i         (ok_q[2]),
    .lane_i       (lane_val),
    .m_axis_tready(m_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .adv_o        (adv)
  );

endmodule

[tb/cylindrical_warp_bilinear_test.sv]
// self-checking stream testbench for the cylindrical warp block
`timescale 1ns / 100ps

module cylindrical_warp_bilinear_test;
  import cwb_pkg::*;

  localparam int unsigned ENTRIES    = 1024;
  localparam int unsigned STORE_COLS = 256;
  localparam longint unsigned QUARTER_TURN_Q16 = 64'd102944;
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam longint unsigned ANGLE_SAT        = 64'hFF_FFFF;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 30;

  typedef struct packed {
    logic [CHAN_W-1:0] chan0;
    logic [CHAN_W-1:0] chan1;
    logic [CHAN_W-1:0] chan2;
    logic              in_range;
  } warp_result_t;

  typedef struct {
    bit           query;
    bit [7:0]     row;
    bit [7:0]     col;
    bit [47:0]    pix;
    bit           fixed;
    warp_result_t fixed_res;
  } directed_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  cylindrical_warp_bilinear dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // mirror of the block state
  longint unsigned tan_tab [ENTRIES];
  longint unsigned sec_tab [ENTRIES];
  bit [47:0]       pix_mem [65536];
  bit              pix_written [65536];
  bit [8:0]        width_reg;
  bit [8:0]        height_reg;
  bit [23:0]       focal_reg;
  bit [23:0]       inv_focal_reg;

  warp_result_t pending_pixels [$];
  int unsigned  src_idle;
  int unsigned  sink_stall;
  int unsigned  errors;
  int unsigned  quiet_cycles;
  int unsigned  n_loads;
  int unsigned  n_hits;
  int unsigned  n_misses;
  int unsigned  n_beats;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  task automatic build_angle_tables();
    longint unsigned x, x2, ts, tc, cu, t, q;
    longint          s, c;
    for (int k = 0; k < ENTRIES; k++) begin
      x = (64'(k) << 31) / ENTRIES;
      if (x >= QUARTER_TURN_Q30) begin
        tan_tab[k] = ANGLE_SAT;
        sec_tab[k] = ANGLE_SAT;
        continue;
      end
      x2 = (x * x) >> 30;
      s  = longint'(x);
      c  = 64'sd1 <<< 30;
      ts = x;
      tc = 64'd1 << 30;
      for (int n = 1; n <= 12; n++) begin
        ts = ((ts * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        tc = ((tc * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) begin
          s = s - longint'(ts);
          c = c - longint'(tc);
        end else begin
          s = s + longint'(ts);
          c = c + longint'(tc);
        end
      end
      if (c <= 0) begin
        tan_tab[k] = ANGLE_SAT;
        sec_tab[k] = ANGLE_SAT;
        continue;
      end
      if (s < 0) s = 0;
      cu = longint'(c);
      t  = ((longint'(s) << 16) + cu / 2) / cu;
      q  = ((64'd1 << 46) + cu / 2) / cu;
      tan_tab[k] = (t > ANGLE_SAT) ? ANGLE_SAT : t;
      sec_tab[k] = (q > ANGLE_SAT) ? ANGLE_SAT : q;
    end
  endtask

  function automatic longint unsigned angle_lookup(input bit use_sec,
                                                   input longint unsigned a);
    longint unsigned p, i, f, j, lo, hi;
    p = a * ENTRIES;
    i = p >> 17;
    f = p & 64'h1_FFFF;
    if (i >= ENTRIES) i = ENTRIES - 1;
    j  = (i + 1 < ENTRIES) ? i + 1 : i;
    lo = use_sec ? sec_tab[i] : tan_tab[i];
    hi = use_sec ? sec_tab[j] : tan_tab[j];
    return (lo * (131072 - f) + hi * f + 65536) >> 17;
  endfunction

  function automatic longint clamp_dim(input bit [8:0] v);
    if (v < 2) return 2;
    if (v > 256) return 256;
    return longint'(v);
  endfunction

  // source position of an output pixel; returns 0 when zero filled
  function automatic bit source_position(input bit [7:0] row, input bit [7:0] col,
                                         output int r0, output int c0,
                                         output int dr, output int dc);
    longint          w, h, dx2, dy2, cpos, rpos, cm, rm;
    longint unsigned dxm, a, tanm, secv, dym, ys;
    r0 = 0; c0 = 0; dr = 0; dc = 0;
    w    = clamp_dim(width_reg);
    h    = clamp_dim(height_reg);
    dx2  = 2 * longint'(col) - w;
    dxm  = (dx2 < 0) ? -dx2 : dx2;
    a    = (dxm * inv_focal_reg + 256) >> 9;
    if (a >= QUARTER_TURN_Q16) return 1'b0;
    tanm = angle_lookup(1'b0, a);
    secv = angle_lookup(1'b1, a);
    cm   = longint'((64'(focal_reg) * tanm + 32768) >> 16);
    cpos = (dx2 < 0) ? w * 128 - cm : w * 128 + cm;
    if (cpos < 0 || cpos >= (w - 1) * 256) return 1'b0;
    dy2  = 2 * longint'(row) - h;
    dym  = longint'((dy2 < 0) ? -dy2 : dy2) * inv_focal_reg;
    ys   = (dym * secv + 65536) >> 17;
    rm   = longint'((ys * focal_reg + (64'd1 << 23)) >> 24);
    rpos = (dy2 < 0) ? h * 128 - rm : h * 128 + rm;
    if (rpos < 0 || rpos >= (h - 1) * 256) return 1'b0;
    c0 = int'(cpos >> 8);
    dc = int'(cpos & 255);
    r0 = int'(rpos >> 8);
    dr = int'(rpos & 255);
    return 1'b1;
  endfunction

  function automatic warp_result_t blend_pixels(input int r0, input int c0,
                                                input int dr, input int dc);
    warp_result_t    res;
    int              a00;
    longint unsigned top, bot, v;
    bit [47:0]       p00, p01, p10, p11;
    a00 = r0 * STORE_COLS + c0;
    p00 = pix_mem[a00];
    p01 = pix_mem[a00 + 1];
    p10 = pix_mem[a00 + STORE_COLS];
    p11 = pix_mem[a00 + STORE_COLS + 1];
    res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      top = (256 - dc) * 64'(p00[ch*16 +: 16]) + dc * 64'(p01[ch*16 +: 16]);
      bot = (256 - dc) * 64'(p10[ch*16 +: 16]) + dc * 64'(p11[ch*16 +: 16]);
      v   = ((256 - dr) * top + dr * bot + 32768) >> 16;
      case (ch)
        0: res.chan0 = v[15:0];
        1: res.chan1 = v[15:0];
        default: res.chan2 = v[15:0];
      endcase
    end
    res.in_range = 1'b1;
    return res;
  endfunction

  // caller stands at a rising edge; valid stays up across back-to-back beats
  task automatic send_beat(input bit query, input bit [7:0] row, input bit [7:0] col,
                           input bit [47:0] pix);
    if ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < src_idle) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= query;
    s_axis_tdata  <= {pix[47:32], pix[31:16], pix[15:0], col, row};
    n_beats++;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic load_pixel(input bit [7:0] row, input bit [7:0] col, input bit [47:0] pix);
    int addr;
    addr = int'(row) * STORE_COLS + int'(col);
    pix_mem[addr]     = pix;
    pix_written[addr] = 1'b1;
    n_loads++;
    send_beat(1'b0, row, col, pix);
  endtask

  // fills any unwritten neighbour first so the block never reads a stale entry
  task automatic fill_neighbours(input int r0, input int c0);
    int addr;
    for (int k = 0; k < 4; k++) begin
      addr = (r0 + k / 2) * STORE_COLS + c0 + k % 2;
      if (!pix_written[addr])
        load_pixel(8'(r0 + k / 2), 8'(c0 + k % 2), {$urandom, $urandom});
    end
  endtask

  task automatic query_pixel(input bit [7:0] row, input bit [7:0] col);
    int           r0, c0, dr, dc;
    warp_result_t res;
    if (source_position(row, col, r0, c0, dr, dc)) begin
      fill_neighbours(r0, c0);
      res = blend_pixels(r0, c0, dr, dc);
      n_hits++;
    end else begin
      res = '0;
      n_misses++;
    end
    pending_pixels.push_back(res);
    send_beat(1'b1, row, col, '0);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cwb_reg_e r, input bit [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (r)
      REG_WIDTH:    width_reg     = v[8:0];
      REG_HEIGHT:   height_reg    = v[8:0];
      REG_FOCAL_IN: focal_reg     = v[23:0];
      default:      inv_focal_reg = v[23:0];
    endcase
  endtask

  // loads leave no result, so allow for their pipeline depth before writing
  task automatic set_geometry(input bit [31:0] w, input bit [31:0] h,
                              input bit [31:0] f, input bit [31:0] inv);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_FOCAL_IN, f);
    write_reg(REG_INV_FOCAL, inv);
  endtask

  // n_items counts every beat sent, neighbour fills included
  task automatic random_traffic(input int n_items, input bit pause_midway);
    int          lim_r, lim_c;
    int unsigned first;
    bit          paused;
    lim_r = (clamp_dim(height_reg) + 2 > 255) ? 255 : int'(clamp_dim(height_reg)) + 2;
    lim_c = (clamp_dim(width_reg) + 2 > 255) ? 255 : int'(clamp_dim(width_reg)) + 2;
    first  = n_beats;
    paused = 1'b0;
    while (int'(n_beats - first) < n_items) begin
      if (pause_midway && !paused && int'(n_beats - first) >= n_items / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(9) < 3)
        load_pixel(8'($urandom), 8'($urandom), {$urandom, $urandom});
      else if ($urandom_range(9) < 8)
        query_pixel(8'($urandom_range(lim_r)), 8'($urandom_range(lim_c)));
      else
        query_pixel(8'($urandom), 8'($urandom));
    end
  endtask

  // sink side: random stall and in-order compare
  always @(posedge clk_i) begin
    warp_result_t want;
    m_axis_tready <= ($urandom_range(99) >= sink_stall);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result beat tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (m_axis_tdata[15:0] !== want.chan0) begin
          $error("chan0_out expected %h got %h", want.chan0, m_axis_tdata[15:0]);
          errors++;
        end
        if (m_axis_tdata[31:16] !== want.chan1) begin
          $error("chan1_out expected %h got %h", want.chan1, m_axis_tdata[31:16]);
          errors++;
        end
        if (m_axis_tdata[47:32] !== want.chan2) begin
          $error("chan2_out expected %h got %h", want.chan2, m_axis_tdata[47:32]);
          errors++;
        end
        if (m_axis_tuser[0] !== want.in_range) begin
          $error("in_range expected %b got %b", want.in_range, m_axis_tuser[0]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    directed_row_t plan [$];
    directed_row_t dr_row;
    int unsigned   wv, hv, fpix;
    int            fr0, fc0, fdr, fdc;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    src_idle      = 0;
    sink_stall    = 0;
    n_loads       = 0;
    n_hits        = 0;
    n_misses      = 0;
    n_beats       = 0;
    width_reg     = 9'd256;
    height_reg    = 9'd256;
    focal_reg     = 24'd65536;
    inv_focal_reg = 24'd65536;
    build_angle_tables();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // centre of the reset geometry maps exactly onto source pixel (128,128)
    plan = '{
      '{0, 8'd128, 8'd128, 48'h3333_2222_1111, 0, '0},
      '{1, 8'd128, 8'd128, '0, 1, '{16'h1111, 16'h2222, 16'h3333, 1'b1}},
      '{0, 8'd128, 8'd128, 48'hFFFF_FFFF_FFFF, 0, '0},
      '{1, 8'd128, 8'd128, '0, 1, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}},
      '{0, 8'd128, 8'd128, 48'h0, 0, '0},
      '{1, 8'd128, 8'd128, '0, 1, '{16'h0, 16'h0, 16'h0, 1'b1}},
      '{0, 8'd255, 8'd255, 48'hFFFF_FFFF_FFFF, 0, '0},
      '{0, 8'd0, 8'd0, 48'h0, 0, '0},
      '{1, 8'd0, 8'd0, '0, 0, '0},
      '{1, 8'd255, 8'd255, '0, 0, '0},
      '{1, 8'd0, 8'd255, '0, 0, '0},
      '{1, 8'd255, 8'd0, '0, 0, '0},
      '{1, 8'd128, 8'd0, '0, 0, '0},
      '{1, 8'd0, 8'd128, '0, 0, '0},
      '{1, 8'd100, 8'd60, '0, 0, '0},
      '{1, 8'd140, 8'd200, '0, 0, '0},
      '{1, 8'd127, 8'd129, '0, 0, '0}
    };
    foreach (plan[i]) begin
      dr_row = plan[i];
      if (!dr_row.query) begin
        load_pixel(dr_row.row, dr_row.col, dr_row.pix);
      end else if (dr_row.fixed) begin
        // zero-weight neighbours still have to hold written data
        if (source_position(dr_row.row, dr_row.col, fr0, fc0, fdr, fdc))
          fill_neighbours(fr0, fc0);
        n_hits++;
        pending_pixels.push_back(dr_row.fixed_res);
        send_beat(1'b1, dr_row.row, dr_row.col, '0);
      end else begin
        query_pixel(dr_row.row, dr_row.col);
      end
    end

    // extremes: clamped dimensions, widest and zero focal, narrowest and widest angle step
    set_geometry(0, 511, 32'hFF_FFFF, 1);
    random_traffic(60, 0);
    set_geometry(3, 2, 0, 32'hFF_FFFF);
    random_traffic(60, 0);
    set_geometry(2, 2, 1, 32'h10_0000);
    random_traffic(40, 0);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 88; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 88; end
        default: begin src_idle = 26; sink_stall = 26; end
      endcase
      wv   = (ph == 7) ? 256 : $urandom_range(40, 2);
      hv   = (ph == 6) ? 256 : $urandom_range(40, 2);
      fpix = $urandom_range(3 * wv, wv / 2 + 1);
      set_geometry(wv, hv, fpix * 256 + $urandom_range(255), (1 << 24) / fpix);
      random_traffic(130, ph == 1);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d pixel loads, %0d in-range and %0d zero-filled queries",
             n_loads, n_hits, n_misses);
    $display("over clamped, extreme and random geometries with source and sink stalls");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
